### hw/rtl/assert_macros.svh
// assertion helpers; empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define AST_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMPLY(name, ante, cons, msg)
`define AST_NEXT(name, ante, cons, msg)
`endif

`endif

### hw/rtl/efb_pkg.sv
package efb_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SEQ_SHIFT = 6;
  localparam int unsigned NUM_ENT  = 7;
  localparam int unsigned PTR_W    = 3;
  localparam int unsigned CFG_IDX_W = 8;

  // slot positions in a frame record
  localparam logic [PTR_W-1:0] ENT_OPEN  = 3'd0;
  localparam logic [PTR_W-1:0] ENT_ADDR  = 3'd1;
  localparam logic [PTR_W-1:0] ENT_CTRL  = 3'd2;
  localparam logic [PTR_W-1:0] ENT_BCC1  = 3'd3;
  localparam logic [PTR_W-1:0] ENT_DATA  = 3'd4;
  localparam logic [PTR_W-1:0] ENT_BCC2  = 3'd5;
  localparam logic [PTR_W-1:0] ENT_CLOSE = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR   = 8'd3;

  localparam logic [BYTE_W-1:0] FLAG_RST   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] MASK_RST   = 8'd32;
  localparam logic [BYTE_W-1:0] ADDR_RST   = 8'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] stuff_mask;
    logic [BYTE_W-1:0] address_value;
  } cfg_t;

  // one item's worth of line bytes: slots start..stop are sent,
  // an escaped slot holds the already masked byte
  typedef struct packed {
    logic [NUM_ENT-1:0][BYTE_W-1:0] bytes;
    logic [NUM_ENT-1:0]             esc;
    logic [PTR_W-1:0]               start;
    logic [PTR_W-1:0]               stop;
  } rec_t;

  typedef struct packed {
    logic busy;
    logic esc_now;
    logic done;
  } ser_stat_t;

endpackage

### hw/rtl/efb_builder.sv
module efb_builder (
  input  logic                       clk,
  input  logic                       rst,
  input  efb_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic [efb_pkg::BYTE_W-1:0] payload_byte,
  input  logic                       first_byte,
  input  logic                       last_byte,
  input  logic                       sequence_bit,
  output logic                       produce,
  output logic                       in_frame,
  output efb_pkg::rec_t              rec
);
  import efb_pkg::*;

  logic [BYTE_W-1:0] payload_check;
  logic [BYTE_W-1:0] ctrl;
  logic [BYTE_W-1:0] bcc1;
  logic [BYTE_W-1:0] check_next;

  function automatic logic needs_esc(input logic [BYTE_W-1:0] b, input cfg_t c);
    needs_esc = (b == c.flag_value) || (b == c.escape_value);
  endfunction

  function automatic logic [BYTE_W-1:0] stuffed(input logic [BYTE_W-1:0] b,
                                                input cfg_t c);
    stuffed = needs_esc(b, c) ? (b ^ c.stuff_mask) : b;
  endfunction

  // header and check bytes
  assign ctrl       = BYTE_W'({sequence_bit, SEQ_SHIFT'(0)});
  assign bcc1       = cfg.address_value ^ ctrl;
  assign check_next = (first_byte ? '0 : payload_check) ^ payload_byte;
  assign produce    = first_byte || in_frame;

  // frame record for this item
  always_comb begin
    rec = '0;
    rec.bytes[ENT_OPEN]  = cfg.flag_value;
    rec.bytes[ENT_ADDR]  = stuffed(cfg.address_value, cfg);
    rec.esc[ENT_ADDR]    = needs_esc(cfg.address_value, cfg);
    rec.bytes[ENT_CTRL]  = stuffed(ctrl, cfg);
    rec.esc[ENT_CTRL]    = needs_esc(ctrl, cfg);
    rec.bytes[ENT_BCC1]  = stuffed(bcc1, cfg);
    rec.esc[ENT_BCC1]    = needs_esc(bcc1, cfg);
    rec.bytes[ENT_DATA]  = stuffed(payload_byte, cfg);
    rec.esc[ENT_DATA]    = needs_esc(payload_byte, cfg);
    rec.bytes[ENT_BCC2]  = stuffed(check_next, cfg);
    rec.esc[ENT_BCC2]    = needs_esc(check_next, cfg);
    rec.bytes[ENT_CLOSE] = cfg.flag_value;
    rec.start = first_byte ? ENT_OPEN : ENT_DATA;
    rec.stop  = last_byte ? ENT_CLOSE : ENT_DATA;
  end

  // running check and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_check <= '0;
      in_frame      <= 1'b0;
    end else if (accept && produce) begin
      payload_check <= check_next;
      in_frame      <= !last_byte;
    end
  end

endmodule

### hw/rtl/efb_serializer.sv
module efb_serializer (
  input  logic                       clk,
  input  logic                       rst,
  input  efb_pkg::cfg_t              cfg,
  input  logic                       load,
  input  efb_pkg::rec_t              rec_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [efb_pkg::BYTE_W-1:0] line_byte,
  output logic                       frame_end,
  output efb_pkg::ser_stat_t         stat
);
  import efb_pkg::*;

  rec_t             rec;
  logic             busy;
  logic [PTR_W-1:0] ptr;
  logic             phase;
  logic             take;
  logic             esc_now;
  logic             done;

  // escape byte goes out first, then the masked byte
  assign esc_now   = rec.esc[ptr] && !phase;
  assign take      = busy && out_ready;
  assign done      = take && !esc_now && (ptr == rec.stop);
  assign out_valid = busy;
  assign line_byte = esc_now ? cfg.escape_value : rec.bytes[ptr];
  assign frame_end = (ptr == ENT_CLOSE);

  assign stat.busy    = busy;
  assign stat.esc_now = esc_now;
  assign stat.done    = done;

  // record register and walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      ptr   <= '0;
      phase <= 1'b0;
    end else if (load) begin
      busy  <= 1'b1;
      ptr   <= rec_in.start;
      phase <= 1'b0;
    end else if (take) begin
      if (esc_now) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        if (ptr == rec.stop) begin
          busy <= 1'b0;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

endmodule

### hw/rtl/escaped_frame_builder.sv
// channel  | valid/ready        | payload
// s        | s_tvalid/s_tready  | tdata: payload_byte, sequence_bit; tuser: first_byte;
//          |                    | tlast: last_byte
// m        | m_tvalid/m_tready  | tdata: line_byte; tlast: frame_end
// cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
// one line byte leaves per cycle while m_tready is high; an item yields 0 to 12 line
// bytes, and a dropped byte is still accepted on s
// the first byte of an item is offered the cycle after it is accepted; the
// next item is taken in the cycle its predecessor's final byte leaves
// reset clears the frame state, the running check and the config to defaults
// a stall on m holds the current byte and, once the record is pending, holds s
`include "assert_macros.svh"

module escaped_frame_builder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [7:0] payload_byte, [8] sequence_bit
  input  logic                          s_tuser,   // [0] first_byte
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] line_byte
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efb_pkg::BYTE_W-1:0]    cfg_data
);
  import efb_pkg::*;

  cfg_t      cfg;
  rec_t      rec;
  ser_stat_t stat;
  logic      accept;
  logic      produce;
  logic      in_frame;
  logic      load;
  logic      m_take;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value    <= FLAG_RST;
      cfg.escape_value  <= ESCAPE_RST;
      cfg.stuff_mask    <= MASK_RST;
      cfg.address_value <= ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLAG:   cfg.flag_value    <= cfg_data;
        REG_ESCAPE: cfg.escape_value  <= cfg_data;
        REG_MASK:   cfg.stuff_mask    <= cfg_data;
        REG_ADDR:   cfg.address_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side: free when no record is pending or its last byte leaves now
  assign s_tready = !stat.busy || stat.done;
  assign accept   = s_tvalid && s_tready;
  assign load     = accept && produce;

  efb_builder u_builder (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .payload_byte (s_tdata[7:0]),
    .first_byte   (s_tuser),
    .last_byte    (s_tlast),
    .sequence_bit (s_tdata[8]),
    .produce      (produce),
    .in_frame     (in_frame),
    .rec          (rec)
  );

  efb_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .load      (load),
    .rec_in    (rec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .line_byte (m_tdata),
    .frame_end (m_tlast),
    .stat      (stat)
  );

  // checks
  assign m_take = m_tvalid && m_tready;

  `AST_IMPLY(a_close_is_flag, m_tvalid && m_tlast, m_tdata == cfg.flag_value, "bad closing byte")
  `AST_NEXT(a_esc_pair, m_take && stat.esc_now, m_tvalid && !stat.esc_now, "escape unpaired")
  `AST_NEXT(a_frame_closes, load && s_tlast, !in_frame, "frame still open after last byte")

endmodule
